@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/sha256_pkg.sv @@
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    word_t      data_word;
    logic [2:0] valid_bytes;
    logic       last_word;
  } in_req_t;

  typedef struct packed {
    word_t      digest_word;
    logic [2:0] word_index;
    logic       digest_end;
  } out_req_t;

  // Word handed from the front to the back: the word, whether it closes a
  // block, and whether that block closes the message.
  typedef struct packed {
    word_t data;
    logic  blk_end;
    logic  msg_end;
  } qword_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] PadByte = 8'h80;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

@@ sv/sha256_if.sv @@
`default_nettype none
interface sha256_in_if;
  import sha256_pkg::*;
  logic    valid;
  logic    ready;
  in_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

interface sha256_out_if;
  import sha256_pkg::*;
  logic     valid;
  logic     ready;
  out_req_t req;
  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface
`default_nettype wire

@@ sv/sha256_front.sv @@
`default_nettype none
module sha256_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  sha256_in_if.sink               in_ch,
  output sha256_pkg::qword_t      q_data,
  output logic                    q_push,
  input  wire logic               q_full
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    F_TAKE = 3'b001,
    F_PAD  = 3'b010,
    F_WAIT = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        in_fire, msg_done;
  logic [2:0]  nb;
  word_t       mask, padw;
  qword_t      qw;
  logic        pad_pend_r, pad_pend_nxt, len_ok_r, len_ok_nxt;

  assign in_ch.ready = (state_r == F_TAKE) && !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign nb = (in_ch.req.valid_bytes > 3'd4) ? 3'd4 : in_ch.req.valid_bytes;

  always_comb begin
    mask = '0;
    padw = '0;
    case (nb)
      3'd0: begin mask = 32'h0000_0000; padw = {PadByte, 24'h0}; end
      3'd1: begin mask = 32'hff00_0000; padw = {8'h0, PadByte, 16'h0}; end
      3'd2: begin mask = 32'hffff_0000; padw = {16'h0, PadByte, 8'h0}; end
      3'd3: begin mask = 32'hffff_ff00; padw = {24'h0, PadByte}; end
      default: begin mask = 32'hffff_ffff; padw = '0; end
    endcase
  end

  // Pad words after the last one: a lone pad word when the last word was
  // full, then zeros until slot fourteen, then the bit count.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    q_push    = 1'b0;
    qw        = '0;
    msg_done  = 1'b0;
    case (state_r)
      F_TAKE: begin
        if (in_fire) begin
          q_push = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (!in_ch.req.last_word) begin
            qw.data  = in_ch.req.data_word;
            bits_nxt = bits_r + 64'd32;
          end else begin
            qw.data  = (in_ch.req.data_word & mask) | padw;
            bits_nxt = bits_r + {58'd0, nb, 3'd0};
            state_nxt = F_PAD;
          end
          qw.blk_end = (fill_r == 4'd15);
        end
      end
      F_PAD: begin
        if (!q_full) begin
          q_push   = 1'b1;
          fill_nxt = fill_r + 4'd1;
          qw.blk_end = (fill_r == 4'd15);
          if (len_ok_r && fill_r == 4'd14)      qw.data = bits_r[63:32];
          else if (len_ok_r && fill_r == 4'd15) qw.data = bits_r[31:0];
          else                                  qw.data = '0;
          if (fill_r == 4'd15 && len_ok_r) begin
            qw.msg_end = 1'b1;
            msg_done   = 1'b1;
          end
          // The first pad word after a full last word carries the pad byte.
          if (pad_pend_r) qw.data = {PadByte, 24'h0};
        end
      end
      default: begin
        state_nxt = F_TAKE;
      end
    endcase
    if (msg_done) begin
      state_nxt = F_TAKE;
      bits_nxt  = '0;
    end
  end

  // len_ok marks that the length words may go out: slot fourteen was reached
  // with no pad byte still pending.
  always_comb begin
    pad_pend_nxt = pad_pend_r;
    len_ok_nxt   = len_ok_r;
    if (state_r == F_TAKE && in_fire && in_ch.req.last_word) begin
      pad_pend_nxt = (nb == 3'd4);
      len_ok_nxt   = (nb != 3'd4) && (fill_r == 4'd13);
    end else if (state_r == F_PAD && !q_full) begin
      pad_pend_nxt = 1'b0;
      if (fill_r == 4'd13) len_ok_nxt = 1'b1;
      if (msg_done) len_ok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_TAKE;
      fill_r     <= '0;
      bits_r     <= '0;
      pad_pend_r <= 1'b0;
      len_ok_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      pad_pend_r <= pad_pend_nxt;
      len_ok_r   <= len_ok_nxt;
    end
  end

  assign q_data = qw;
endmodule
`default_nettype wire

@@ sv/sha256_queue.sv @@
`default_nettype none
module sha256_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha256_pkg::qword_t wr_data,
  input  wire logic               wr_en,
  output logic                    full,
  output sha256_pkg::qword_t      rd_data,
  output logic                    rd_valid,
  input  wire logic               rd_en
);
  import sha256_pkg::*;

  qword_t           mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;

  assign full     = (cnt_r == QPtrW'(0) + (QPtrW+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + QPtrW'(1);
      if (rd_en) rp_r <= rp_r + QPtrW'(1);
      cnt_r <= cnt_r + (QPtrW+1)'(wr_en) - (QPtrW+1)'(rd_en);
    end
  end
endmodule
`default_nettype wire

@@ sv/sha256_back.sv @@
`default_nettype none
module sha256_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha256_pkg::qword_t q_data,
  input  wire logic               q_valid,
  output logic                    q_pop,
  sha256_out_if.source            out_ch
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    B_LOAD = 4'b0001,
    B_RND  = 4'b0010,
    B_ADD  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_t;

  bstate_t    state_r, state_nxt;
  word_t      w_r [16];
  word_t      h_r [8];
  word_t      v_r [8];
  logic [5:0] rnd_r;
  logic [2:0] oidx_r;
  logic       fin_r;
  word_t      s0, s1, wnew, wcur, t1, t2, e, a;

  assign q_pop = (state_r == B_LOAD) && q_valid;

  always_comb begin
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = w_r[0] + s0 + w_r[9] + s1;
    wcur = w_r[0];
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + (v_r[6] ^ (e & (v_r[5] ^ v_r[6]))) + RoundK[rnd_r] + wcur;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) | (v_r[2] & (a | v_r[1])));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_LOAD: if (q_valid && q_data.blk_end) state_nxt = B_RND;
      B_RND:  if (rnd_r == 6'd63) state_nxt = B_ADD;
      B_ADD:  state_nxt = fin_r ? B_EMIT : B_LOAD;
      B_EMIT: if (out_ch.ready && oidx_r == 3'd7) state_nxt = B_LOAD;
      default: state_nxt = B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == B_LOAD && q_valid) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= q_data.data;
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (state_r == B_RND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_data.blk_end) fin_r <= q_data.msg_end;
      if (state_r == B_RND) rnd_r <= rnd_r + 6'd1;
      if (state_r == B_ADD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (state_r == B_EMIT && out_ch.ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7)
          for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
      end
    end
  end

  assign out_ch.valid           = (state_r == B_EMIT);
  assign out_ch.req.digest_word = h_r[oidx_r];
  assign out_ch.req.word_index  = oidx_r;
  assign out_ch.req.digest_end  = (oidx_r == 3'd7);
endmodule
`default_nettype wire

@@ sv/sha256_message_hasher_core.sv @@
// Channel | Dir | Payload                                | Handshake
// in_ch   | in  | data_word[31:0] valid_bytes[2:0] last  | valid/ready
// out_ch  | out | digest_word[31:0] word_index[2:0] end  | valid/ready
// The front adds pad words and takes one word per cycle into a four-entry queue,
// except while padding or when the queue is full. The back loads a 16-word block,
// runs 64 rounds and does the final add, one block at a time on one round unit.
// A finished message yields eight digest requests, one per cycle while ready.
// Synchronous reset restores the initial hash and an empty block.
`default_nettype none
module sha256_message_hasher_core (
  input wire logic     clk,
  input wire logic     rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  qword_t fq_data, qb_data;
  logic   fq_push, q_full, q_valid, q_pop;

  sha256_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(fq_data), .q_push(fq_push), .q_full(q_full)
  );

  sha256_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_data(fq_data), .wr_en(fq_push), .full(q_full),
    .rd_data(qb_data), .rd_valid(q_valid), .rd_en(q_pop)
  );

  sha256_back u_back (
    .clk(clk), .rst_n(rst_n), .q_data(qb_data), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

@@ sv/sha256_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_index,
  input wire logic       out_end
);
  `ASSERT_IMPL(a_end_idx, out_valid, out_end == (out_index == 3'd7), "end flag mismatch")
  `ASSERT_NEXT(a_idx_step, out_valid && out_ready && !out_end, out_valid, "digest burst broke")
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "valid dropped")
  `ASSERT_NEXT(a_idx_inc, out_valid && out_ready && !out_end,
    out_index == $past(out_index) + 3'd1, "index did not advance")
endmodule

bind sha256_message_hasher_core sha256_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_index(out_ch.req.word_index), .out_end(out_ch.req.digest_end)
);
`default_nettype wire

@@ test/sha256_message_hasher_core_tb.sv @@
`default_nettype none
module sha256_message_hasher_core_tb;
  import sha256_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned TailCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_message_hasher_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  word_t          chain_st [8];
  word_t          blk_buf [16];
  logic [3:0]     fill_cnt;
  logic [63:0]    bit_cnt;
  in_req_t        send_q [$];
  out_req_t       digest_q [$];
  int unsigned    err_cnt = 0;
  int unsigned    req_sent = 0;
  int unsigned    msg_sent = 0;
  int unsigned    digest_seen = 0;
  int unsigned    idle_cnt = 0;
  int unsigned    src_wait = 0;
  int unsigned    snk_wait = 0;
  bit             hold_src = 1'b0;
  bit             stim_done = 1'b0;

  function automatic word_t rr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    word_t w [64];
    word_t v [8];
    word_t t1;
    word_t t2;
    for (int i = 0; i < 16; i++) w[i] = blk_buf[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = chain_st[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + RoundK[i] + w[i];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_st[i] += v[i];
  endtask

  task automatic buffer_word(input word_t w);
    blk_buf[fill_cnt] = w;
    fill_cnt = fill_cnt + 4'd1;
    if (fill_cnt == 4'd0) compress_block();
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain_st[i] = InitHash[i];
    fill_cnt = '0;
    bit_cnt = '0;
  endtask

  task automatic predict_digest(input in_req_t r);
    int unsigned nb;
    word_t mask;
    out_req_t o;
    if (!r.last_word) begin
      buffer_word(r.data_word);
      bit_cnt += 64'd32;
      return;
    end
    nb = (r.valid_bytes > 3'd4) ? 4 : int'(r.valid_bytes);
    bit_cnt += 64'(8 * nb);
    if (nb == 4) begin
      buffer_word(r.data_word);
      buffer_word({PadByte, 24'h0});
    end else begin
      mask = (nb == 0) ? '0 : ('1 << (32 - 8 * nb));
      buffer_word((r.data_word & mask) | (word_t'(PadByte) << (24 - 8 * nb)));
    end
    while (fill_cnt != 4'd14) buffer_word('0);
    buffer_word(bit_cnt[63:32]);
    buffer_word(bit_cnt[31:0]);
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain_st[i];
      o.word_index = 3'(i);
      o.digest_end = (i == 7);
      digest_q.push_back(o);
    end
    clear_hash();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    err_cnt++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
  endtask

  function automatic in_req_t mk(input word_t d, input logic [2:0] nb, input logic lst);
    in_req_t r;
    r.data_word = d;
    r.valid_bytes = nb;
    r.last_word = lst;
    return r;
  endfunction

  task automatic add_message(input int unsigned nwords, input bit tidy);
    for (int i = 0; i < nwords; i++)
      send_q.push_back(mk($urandom, tidy ? 3'd4 : 3'($urandom), 1'b0));
    send_q.push_back(mk($urandom, tidy ? 3'($urandom_range(0, 4)) : 3'($urandom), 1'b1));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req <= '0;
      src_wait <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) begin
        predict_digest(in_ch.req);
        req_sent++;
        if (in_ch.req.last_word) msg_sent++;
      end
      if (src_wait != 0) begin
        src_wait <= src_wait - 1;
        in_ch.valid <= 1'b0;
      end else if (send_q.size() != 0 && !hold_src) begin
        in_ch.req <= send_q.pop_front();
        in_ch.valid <= 1'b1;
        src_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        digest_seen++;
        if (digest_q.size() == 0) begin
          report("unexpected digest word", out_ch.req.digest_word, '0);
        end else begin
          if (out_ch.req.digest_word != digest_q[0].digest_word)
            report("digest_word", out_ch.req.digest_word, digest_q[0].digest_word);
          if (out_ch.req.word_index != digest_q[0].word_index)
            report("word_index", 32'(out_ch.req.word_index), 32'(digest_q[0].word_index));
          if (out_ch.req.digest_end != digest_q[0].digest_end)
            report("digest_end", 32'(out_ch.req.digest_end), 32'(digest_q[0].digest_end));
          void'(digest_q.pop_front());
        end
      end
      if (snk_wait != 0) begin
        snk_wait <= snk_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        snk_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (rst_n && !stim_done) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("sha256_message_hasher_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req = '0;
    out_ch.ready = 1'b0;
    clear_hash();
    for (int i = 0; i < 16; i++) blk_buf[i] = '0;

    // Directed: empty message, every byte count, oversized counts, padding spill.
    send_q.push_back(mk(32'hFFFF_FFFF, 3'd0, 1'b1));
    for (int nb = 1; nb <= 7; nb++)
      send_q.push_back(mk(32'hFFFF_FFFF, 3'(nb), 1'b1));
    send_q.push_back(mk(32'h0000_0000, 3'd4, 1'b1));
    send_q.push_back(mk(32'h6162_6300, 3'd3, 1'b1));
    for (int i = 0; i < 13; i++) send_q.push_back(mk(32'hA5A5_A5A5, 3'd1, 1'b0));
    send_q.push_back(mk(32'h5A5A_5A5A, 3'd4, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (send_q.size() == 0 && msg_sent == 11);
    hold_src = 1'b1;
    wait (digest_q.size() == 0);
    hold_src = 1'b0;

    for (int m = 0; m < 20; m++) begin
      if (m % 5 == 4) add_message($urandom_range(0, 20), 1'b0);
      else add_message($urandom_range(0, 9), 1'b1);
    end

    wait (send_q.size() == 0 && !in_ch.valid);
    wait (digest_q.size() == 0);
    stim_done = 1'b1;
    repeat (TailCycles) @(posedge clk);
    $display("covered %0d input words in %0d messages, %0d digest words checked",
             req_sent, msg_sent, digest_seen);
    if (err_cnt == 0) begin
      $display("sha256_message_hasher_core_tb: done, clean");
    end else begin
      $display("sha256_message_hasher_core_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
